[rtl/core/kway_sorted_merge_dedup_top_defines.svh]
// Assertion macros for the k-way sorted merge block.
`ifndef KWAY_SORTED_MERGE_DEDUP_TOP_DEFINES_SVH
`define KWAY_SORTED_MERGE_DEDUP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define KWMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KWMD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KWMD_ASSERT(lbl, prop, msg)
`define KWMD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[rtl/core/kwmd_pkg.sv]
// Package with field widths and register indexes of the k-way sorted merge block.
`timescale 1ns / 1ps
package kwmd_pkg;
  localparam int LANE_W      = 3;
  localparam int IDENT_PORT_W = 64;
  localparam int MASK_W      = 8;
  localparam int CNT_W       = 4;
  localparam int CAP_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_CAP  = 1'b1;

  localparam logic [CNT_W-1:0] LANE_COUNT_RST = 4'd1;
  localparam logic [CAP_W-1:0] CHUNK_CAP_RST  = 16'd1024;
endpackage

[rtl/core/kwmd_in_if.sv]
// Input channel carrying one lane identifier or end mark per item.
`timescale 1ns / 1ps
interface kwmd_in_if;
  import kwmd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [LANE_W-1:0]       lane;
  logic [IDENT_PORT_W-1:0] ident;
  logic                    lane_end;

  modport source (output valid, output lane, output ident, output lane_end, input ready);
  modport sink   (input valid, input lane, input ident, input lane_end, output ready);
endinterface

[rtl/core/kwmd_out_if.sv]
// Output channel carrying one merged identifier or scan end per item.
`timescale 1ns / 1ps
interface kwmd_out_if;
  import kwmd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDENT_PORT_W-1:0] merged_ident;
  logic                    chunk_last;
  logic                    scan_end;
  logic [MASK_W-1:0]       await_mask;

  modport source (output valid, output merged_ident, output chunk_last, output scan_end,
                  output await_mask, input ready);
  modport sink   (input valid, input merged_ident, input chunk_last, input scan_end,
                  input await_mask, output ready);
endinterface

[rtl/core/kway_sorted_merge_dedup_top.sv]
// K-way sorted merge with duplicate removal: top level.
// The block merges up to MAX_LANES ascending identifier streams into one
// ascending stream in which every identifier appears once.
// Items arrive on in_i, each naming a lane and giving its next identifier or
// an end mark. Results leave on out_o: a merged identifier with its chunk
// flag, or a scan end item, always with the mask of lanes that must send next.
// An accepted item is held in an input register; once the output register
// can take a new item, the lane update, the minimum search over all heads and
// the chunk count are done in one pass into the output register. A result
// passes the input register and then the output register before it leaves,
// and one item is taken every cycle while out_o is ready.
// The pace is set by the lane state loop: each item sees the heads left by
// the one before it.
// When out_o stalls, the output register holds its item and the input
// register takes one more item; in_i then drops ready until out_o moves.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must do so only
// while the block is idle, as the block does not enforce it. Reset clears all lane flags and the
// chunk count and sets lane_count to 1 and chunk_capacity to 1024; there is no clearing pass.
`timescale 1ns / 1ps
`include "kway_sorted_merge_dedup_top_defines.svh"
module kway_sorted_merge_dedup_top #(
  parameter int MAX_LANES   = 8,
  parameter int IDENT_WIDTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kwmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kwmd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  kwmd_in_if.sink                           in_i,
  kwmd_out_if.source                        out_o
);
  import kwmd_pkg::*;

  localparam int NODES = 1 << $clog2(MAX_LANES);
  localparam int TREE  = 2 * NODES - 1;
  localparam int NW    = ((CNT_W > $clog2(MAX_LANES + 1)) ? CNT_W : $clog2(MAX_LANES + 1)) + 1;

  logic [CNT_W-1:0] lane_count_q;
  logic [CAP_W-1:0] chunk_cap_q;

  logic                   in_valid_q;
  logic [LANE_W-1:0]      lane_q;
  logic [IDENT_WIDTH-1:0] ident_q;
  logic                   lane_end_q;

  logic [IDENT_WIDTH-1:0] head_q [MAX_LANES];
  logic [MAX_LANES-1:0]   head_valid_q, head_valid_d;
  logic [MAX_LANES-1:0]   lane_done_q, lane_done_d;
  logic [CAP_W-1:0]       chunk_fill_q, chunk_fill_d;

  logic                    out_valid_q;
  logic [IDENT_PORT_W-1:0] merged_q, merged_d;
  logic                    last_q, last_d;
  logic                    scan_end_q, scan_end_d;
  logic [MASK_W-1:0]       await_q, await_d;

  logic                   adv;
  logic                   res_valid;
  logic [NW-1:0]          n_act;
  logic [MAX_LANES-1:0]   act;
  logic [MAX_LANES-1:0]   wr;
  logic [MAX_LANES-1:0]   hv1, dn1, hv2, aw;
  logic [IDENT_WIDTH-1:0] head_eff [MAX_LANES];
  logic                   nv [TREE];
  logic [IDENT_WIDTH-1:0] nval [TREE];
  logic [CAP_W-1:0]       cap, fill_inc;

  assign adv       = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_count_q <= LANE_COUNT_RST;
      chunk_cap_q  <= CHUNK_CAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LANE_COUNT: lane_count_q <= cfg_data_i[CNT_W-1:0];
        REG_CHUNK_CAP:  chunk_cap_q  <= cfg_data_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      lane_q     <= in_i.lane;
      ident_q    <= in_i.ident[IDENT_WIDTH-1:0];
      lane_end_q <= in_i.lane_end;
    end
  end

  always_comb begin
    if (lane_count_q == '0) begin
      n_act = NW'(1);
    end else if ({{(NW-CNT_W){1'b0}}, lane_count_q} > NW'(MAX_LANES)) begin
      n_act = NW'(MAX_LANES);
    end else begin
      n_act = {{(NW-CNT_W){1'b0}}, lane_count_q};
    end
    for (int i = 0; i < MAX_LANES; i++) begin
      act[i] = NW'(i) < n_act;
      wr[i]  = in_valid_q && (NW'(lane_q) == NW'(i)) && act[i] &&
               !(head_valid_q[i] || lane_done_q[i]);
      hv1[i] = head_valid_q[i] || (wr[i] && !lane_end_q);
      dn1[i] = lane_done_q[i] || (wr[i] && lane_end_q);
      head_eff[i] = (wr[i] && !lane_end_q) ? ident_q : head_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      if (i < MAX_LANES) begin
        nv[NODES-1+i]   = hv1[i] && act[i];
        nval[NODES-1+i] = head_eff[i];
      end else begin
        nv[NODES-1+i]   = 1'b0;
        nval[NODES-1+i] = '0;
      end
    end
    for (int k = NODES - 2; k >= 0; k--) begin
      if (nv[2*k+1] && (!nv[2*k+2] || nval[2*k+1] <= nval[2*k+2])) begin
        nv[k]   = 1'b1;
        nval[k] = nval[2*k+1];
      end else begin
        nv[k]   = nv[2*k+2];
        nval[k] = nval[2*k+2];
      end
    end
  end

  always_comb begin
    cap          = (chunk_cap_q == '0) ? CAP_W'(1) : chunk_cap_q;
    fill_inc     = chunk_fill_q + CAP_W'(1);
    head_valid_d = hv1;
    lane_done_d  = dn1;
    chunk_fill_d = chunk_fill_q;
    hv2          = hv1;
    res_valid    = 1'b0;
    merged_d     = '0;
    last_d       = 1'b0;
    scan_end_d   = 1'b0;
    if ((dn1 & act) == act) begin
      res_valid    = 1'b1;
      last_d       = chunk_fill_q != '0;
      scan_end_d   = 1'b1;
      head_valid_d = '0;
      lane_done_d  = '0;
      chunk_fill_d = '0;
      hv2          = '0;
    end else if (((hv1 & act) != '0) && (((hv1 | dn1) & act) == act)) begin
      res_valid = 1'b1;
      merged_d  = IDENT_PORT_W'(nval[0]);
      for (int i = 0; i < MAX_LANES; i++) begin
        hv2[i] = hv1[i] && !(act[i] && head_eff[i] == nval[0]);
      end
      head_valid_d = hv2;
      if (fill_inc >= cap || fill_inc == '0) begin
        last_d       = 1'b1;
        chunk_fill_d = '0;
      end else begin
        chunk_fill_d = fill_inc;
      end
    end
    aw = act & ~(hv2 | lane_done_d);
    await_d = '0;
    for (int j = 0; j < MASK_W; j++) begin
      if (j < MAX_LANES) begin
        await_d[j] = aw[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= '0;
      lane_done_q  <= '0;
      chunk_fill_q <= '0;
      out_valid_q  <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q && res_valid;
      if (in_valid_q) begin
        head_valid_q <= head_valid_d;
        lane_done_q  <= lane_done_d;
        chunk_fill_q <= chunk_fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q) begin
      for (int i = 0; i < MAX_LANES; i++) begin
        if (wr[i] && !lane_end_q) begin
          head_q[i] <= ident_q;
        end
      end
      merged_q   <= merged_d;
      last_q     <= last_d;
      scan_end_q <= scan_end_d;
      await_q    <= await_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_ident = merged_q;
  assign out_o.chunk_last   = last_q;
  assign out_o.scan_end     = scan_end_q;
  assign out_o.await_mask   = await_q;

  `KWMD_ASSERT(a_end_ident_zero, out_valid_q && scan_end_q |-> merged_q == '0, "scan end item carries an identifier")
  `KWMD_ASSERT(a_end_clears, adv && in_valid_q && res_valid && scan_end_d |=> head_valid_q == '0 && lane_done_q == '0 && chunk_fill_q == '0, "lane state not cleared after scan end")
  `KWMD_ASSERT_RST(a_ready_only_stall, !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready, "input stalled without a full pipeline")
endmodule
